### rtl/core/i2cm_pkg.sv
package i2cm_pkg;

    // command codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // sequencer phases, one-hot
    typedef enum logic [14:0] {
        PH_IDLE      = 15'h0001,
        PH_START2    = 15'h0002,
        PH_START3    = 15'h0004,
        PH_STOP2     = 15'h0008,
        PH_STOP3     = 15'h0010,
        PH_WR_LOW    = 15'h0020,
        PH_WR_HIGH   = 15'h0040,
        PH_WACK_SET  = 15'h0080,
        PH_WACK_HIGH = 15'h0100,
        PH_WACK_SMP  = 15'h0200,
        PH_RD_SMP    = 15'h0400,
        PH_RD_HIGH   = 15'h0800,
        PH_RACK_SET  = 15'h1000,
        PH_RACK_HIGH = 15'h2000,
        PH_RD_END    = 15'h4000
    } t_phase;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BIT_CNT_W  = 3;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

    // one tick transaction from the slave side
    typedef struct packed {
        logic              cmd_valid;
        t_op               op;
        logic [BYTE_W-1:0] data_byte;
        logic              send_ack;
        logic              sda_level;
    } t_tick;

    // one result transaction toward the master side
    typedef struct packed {
        logic              scl_pull_low;
        logic              sda_pull_low;
        logic              busy_res;
        logic              done_res;
        logic              ack_received;
        logic [BYTE_W-1:0] read_byte;
    } t_result;

endpackage

### rtl/core/i2c_master_byte_engine_unit.sv
// i2c master byte engine: every slave-side transaction is one half-period
// tick of the bus clock and yields exactly one master-side transaction with
// the open-drain drive of scl and sda after that tick, plus busy, done, the
// write ack status and the read byte. a tick is taken every clock cycle while the skid
// register is empty; its result is registered in the output register, or in the skid
// register while the output is held, so the two-entry output stage takes one more
// tick while the downstream side stalls. the rate is set by the sequencer state
// update, a single combinational step per tick. commands offered while a sequence
// runs are dropped; a start or stop takes 3 ticks, a byte write or read takes 19
// ticks. the tick rate itself comes from a prescaler outside.
module i2c_master_byte_engine_unit
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [8] send_ack, [9] sda_level, [15:10] zero
    input  logic [15:0] s_axis_tdata,
    // [0] cmd_valid, [2:1] op
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
    // [4] ack_received, [12:5] read_byte, [15:13] zero
    output logic [15:0] m_axis_tdata
);

    t_tick   tick;
    t_result res;
    logic    accept;
    logic    pop;

    // output register and skid register
    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    // unpack the slave-side transaction
    assign tick = '{
        cmd_valid: s_axis_tuser[0],
        op:        t_op'(s_axis_tuser[2:1]),
        data_byte: s_axis_tdata[7:0],
        send_ack:  s_axis_tdata[8],
        sda_level: s_axis_tdata[9]
    };

    // a new tick is taken as long as the skid slot is free
    assign s_axis_tready = ~r_skid_valid;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign pop           = r_out_valid & m_axis_tready;

    // sequencer: state advances only on an accepted tick
    i2cm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_tick   (tick),
        .o_res    (res)
    );

    // control of the two-entry output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= accept;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload moves, no reset needed
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end else if (!r_out_valid) begin
            if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    // pack the master-side transaction
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.read_byte, r_out.ack_received,
                            r_out.done_res, r_out.busy_res,
                            r_out.sda_pull_low, r_out.scl_pull_low};

`ifndef ASSERT_OFF
    // the skid slot is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds data while output register is empty");

    // a finishing tick never also reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]))
        else $error("done and busy reported together");

    // ack status and read byte show only on a finishing tick
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[4] || (m_axis_tdata[12:5] != 8'd0)))
        |-> m_axis_tdata[3])
        else $error("ack or read byte reported outside a finishing tick");

    // with the skid slot full, no tick may be taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("skid register lost data while output stalled");
`endif

endmodule

### rtl/core/i2cm_seq.sv
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_tick   i_tick,
    output t_result o_res
);

    t_phase                r_phase, n_phase;
    logic [BIT_CNT_W-1:0]  r_bit_count, n_bit_count;
    logic [BYTE_W-1:0]     r_shift, n_shift;
    logic                  r_ack_choice, n_ack_choice;
    logic                  r_scl_low, n_scl_low;
    logic                  r_sda_low, n_sda_low;
    logic                  busy;
    logic                  done;
    logic                  ackr;
    logic [BYTE_W-1:0]     rbyte;

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_scl_low    = r_scl_low;
        n_sda_low    = r_sda_low;
        busy         = 1'b1;
        done         = 1'b0;
        ackr         = 1'b0;
        rbyte        = '0;
        case (r_phase)
            PH_START2: begin
                n_sda_low = 1'b1;
                n_phase   = PH_START3;
            end
            PH_START3: begin
                n_scl_low = 1'b1;
                n_phase   = PH_IDLE;
                done      = 1'b1;
            end
            PH_STOP2: begin
                n_scl_low = 1'b0;
                n_phase   = PH_STOP3;
            end
            PH_STOP3: begin
                n_sda_low = 1'b0;
                n_phase   = PH_IDLE;
                done      = 1'b1;
            end
            PH_WR_LOW: begin
                n_scl_low = 1'b1;
                n_sda_low = ~r_shift[r_bit_count];
                n_phase   = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
                n_scl_low = 1'b0;
                if (r_bit_count == '0) begin
                    n_phase = PH_WACK_SET;
                end else begin
                    n_bit_count = r_bit_count - 1'b1;
                    n_phase     = PH_WR_LOW;
                end
            end
            PH_WACK_SET: begin
                n_scl_low = 1'b1;
                n_sda_low = 1'b0;
                n_phase   = PH_WACK_HIGH;
            end
            PH_WACK_HIGH: begin
                n_scl_low = 1'b0;
                n_phase   = PH_WACK_SMP;
            end
            PH_WACK_SMP: begin
                ackr      = ~i_tick.sda_level;
                n_scl_low = 1'b1;
                n_phase   = PH_IDLE;
                done      = 1'b1;
            end
            PH_RD_SMP: begin
                n_shift   = {r_shift[BYTE_W-2:0], i_tick.sda_level};
                n_scl_low = 1'b1;
                if (r_bit_count == '0) begin
                    n_phase = PH_RACK_SET;
                end else begin
                    n_bit_count = r_bit_count - 1'b1;
                    n_phase     = PH_RD_HIGH;
                end
            end
            PH_RD_HIGH: begin
                n_scl_low = 1'b0;
                n_phase   = PH_RD_SMP;
            end
            PH_RACK_SET: begin
                n_sda_low = r_ack_choice;
                n_phase   = PH_RACK_HIGH;
            end
            PH_RACK_HIGH: begin
                n_scl_low = 1'b0;
                n_phase   = PH_RD_END;
            end
            PH_RD_END: begin
                n_scl_low = 1'b1;
                n_sda_low = 1'b0;
                rbyte     = r_shift;
                n_phase   = PH_IDLE;
                done      = 1'b1;
            end
            default: begin
                // idle, and any unknown code behaves as idle
                n_phase = PH_IDLE;
                busy    = 1'b0;
                if (i_tick.cmd_valid) begin
                    busy = 1'b1;
                    case (i_tick.op)
                        OP_START: begin
                            n_scl_low = 1'b0;
                            n_sda_low = 1'b0;
                            n_phase   = PH_START2;
                        end
                        OP_STOP: begin
                            n_sda_low = 1'b1;
                            n_phase   = PH_STOP2;
                        end
                        OP_WRITE: begin
                            n_shift     = i_tick.data_byte;
                            n_bit_count = LAST_BIT;
                            n_scl_low   = 1'b1;
                            n_sda_low   = ~i_tick.data_byte[BYTE_W-1];
                            n_phase     = PH_WR_HIGH;
                        end
                        default: begin
                            n_shift      = '0;
                            n_bit_count  = LAST_BIT;
                            n_ack_choice = i_tick.send_ack;
                            n_scl_low    = 1'b0;
                            n_sda_low    = 1'b0;
                            n_phase      = PH_RD_SMP;
                        end
                    endcase
                end
            end
        endcase
        if (done) begin
            busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_ack_choice <= 1'b0;
            r_scl_low    <= 1'b0;
            r_sda_low    <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_scl_low    <= n_scl_low;
            r_sda_low    <= n_sda_low;
        end
    end

    assign o_res = '{
        scl_pull_low: n_scl_low,
        sda_pull_low: n_sda_low,
        busy_res:     busy,
        done_res:     done,
        ack_received: ackr,
        read_byte:    rbyte
    };

endmodule
